@@ hdl/smac_pkg.sv @@
// ----------------------------------------------------------------------------
// smac_pkg
// shared types and constants of the shadow memory access checker
// ----------------------------------------------------------------------------
package smac_pkg;

   localparam int unsigned SHADOW_ENTRIES = 65536;
   localparam int unsigned GRAIN_SHIFT    = 3;

   localparam int unsigned GRAIN_BYTES = 1 << GRAIN_SHIFT;
   localparam int unsigned GRAIN_MASK  = GRAIN_BYTES - 1;
   localparam int unsigned IDX_W       = $clog2(SHADOW_ENTRIES);
   localparam int unsigned COUNT_W     = IDX_W + 1;
   localparam int unsigned ADDR_W      = 64;
   localparam int unsigned LEN_W       = 20;
   localparam int unsigned CODE_W      = 8;
   localparam int unsigned STATUS_W    = 3;
   localparam int unsigned OP_W        = 2;
   localparam int unsigned CSR_IDX_W   = 2;
   // bytes covered by the shadow store
   localparam int unsigned WIN_LIMIT   = SHADOW_ENTRIES * GRAIN_BYTES;
   localparam int unsigned WIN_BITS    = $clog2(WIN_LIMIT) + 1;
   // width of window offsets after the range check
   localparam int unsigned OFF_W       = ((WIN_BITS > LEN_W) ? WIN_BITS : LEN_W) + 2;
   localparam int unsigned LAST_W      = LEN_W + 1;

   localparam logic [CODE_W-1:0] REDZONE_RESET = 8'd252;

   typedef enum logic [OP_W-1:0] {
      OP_CHECK_WORD   = 2'd0,
      OP_CHECK_REGION = 2'd1,
      OP_FILL         = 2'd2,
      OP_MARK_ALLOC   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_CLEAN    = 3'd0,
      ST_POISONED = 3'd1,
      ST_USER     = 3'd2,
      ST_SKIPPED  = 3'd3,
      ST_REJECTED = 3'd4,
      ST_MARKED   = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE  = 2'd0,
      CSR_BASE    = 2'd1,
      CSR_WBYTES  = 2'd2,
      CSR_REDZONE = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      JOB_REPORT = 2'd0,
      JOB_WORD   = 2'd1,
      JOB_REGION = 2'd2,
      JOB_FILL   = 2'd3
   } job_kind_type;

   typedef enum logic [2:0] {
      B_CLEAR        = 3'd0,
      B_IDLE         = 3'd1,
      B_WORD_READ    = 3'd2,
      B_WORD_CHECK   = 3'd3,
      B_REGION_READ  = 3'd4,
      B_REGION_CHECK = 3'd5,
      B_FILL         = 3'd6,
      B_EMIT         = 3'd7
   } back_state_type;

   // one classified item on its way from front to back
   typedef struct packed {
      job_kind_type             kind;
      status_type               status;
      logic [ADDR_W-1:0]        address;
      logic [LEN_W-1:0]         length;
      logic                     write;
      logic [IDX_W-1:0]         grain_first;
      logic [COUNT_W-1:0]       grain_count;
      logic [GRAIN_SHIFT-1:0]   lo;
      logic [GRAIN_SHIFT-1:0]   hi;
      logic [LAST_W-1:0]        word_last;
      logic [CODE_W-1:0]        code;
      logic [COUNT_W-1:0]       zero_count;
      logic [GRAIN_SHIFT-1:0]   tail;
   } job_type;

   typedef struct packed {
      logic                 enable;
      logic [ADDR_W-1:0]    base_eff;
      logic [LEN_W-1:0]     window_bytes;
      logic [CODE_W-1:0]    redzone;
   } cfg_type;

endpackage

@@ hdl/shadow_memory_access_checker_core.sv @@
// ----------------------------------------------------------------------------
// shadow_memory_access_checker_core
// shadow memory access checker: word and region checks, poison fill and
// allocation marking over a byte-per-grain shadow store
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  operation, address, length,
//                                                object_length, store,
//                                                fill_code
//   rsp_      out         rsp_valid / rsp_stall  status, report_address,
//                                                report_length, report_write
//   csr_      in          csr_valid / csr_ready  csr_index, csr_data
//
// shadow access: an item that needs no shadow access goes straight to emit in the
//   back unit, a word check reads one grain, a region check reads each grain
//   walked and a fill or allocation writes each grain; all use the single store port
// reset: synchronous; afterwards the shadow store is swept to zero, one grain
//   per cycle, with req_stall high; csr writes are taken
// stalls: a two-entry queue decouples classification from the back unit, and
//   the result register lets the back unit finish while rsp_stall is high
// ----------------------------------------------------------------------------
module shadow_memory_access_checker_core (
   input  logic                                clock,
   input  logic                                reset,
   // item channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [smac_pkg::OP_W-1:0]           req_operation,
   input  logic [smac_pkg::ADDR_W-1:0]         req_address,
   input  logic [smac_pkg::LEN_W-1:0]          req_length,
   input  logic [smac_pkg::LEN_W-1:0]          req_object_length,
   input  logic                                req_store,
   input  logic [smac_pkg::CODE_W-1:0]         req_fill_code,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [smac_pkg::STATUS_W-1:0]       rsp_status,
   output logic [smac_pkg::ADDR_W-1:0]         rsp_report_address,
   output logic [smac_pkg::LEN_W-1:0]          rsp_report_length,
   output logic                                rsp_report_write,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [smac_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [smac_pkg::ADDR_W-1:0]         csr_data
);

   // configuration registers
   logic                                enable_ff;
   logic [smac_pkg::ADDR_W-1:0]         base_ff;
   logic [smac_pkg::LEN_W-1:0]          wbytes_ff;
   logic [smac_pkg::CODE_W-1:0]         redzone_ff;
   smac_pkg::cfg_type                   cfg;

   // front to queue to back
   logic                                push;
   smac_pkg::job_type                   push_job;
   smac_pkg::job_type                   head;
   logic                                empty;
   logic                                full;
   logic                                pop;
   logic                                clearing;
   logic                                csr_write;

   // registers are always writable
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         base_ff    <= '0;
         wbytes_ff  <= '0;
         redzone_ff <= smac_pkg::REDZONE_RESET;
      end else if (csr_write) begin
         case (smac_pkg::csr_index_type'(csr_index))
            smac_pkg::CSR_ENABLE:  enable_ff  <= csr_data[0];
            smac_pkg::CSR_BASE:    base_ff    <= csr_data;
            smac_pkg::CSR_WBYTES:  wbytes_ff  <= csr_data[smac_pkg::LEN_W-1:0];
            smac_pkg::CSR_REDZONE: redzone_ff <= csr_data[smac_pkg::CODE_W-1:0];
            default: begin
               enable_ff <= enable_ff;
            end
         endcase
      end
   end

   // window base is taken grain aligned
   always_comb begin
      cfg.enable       = enable_ff;
      cfg.base_eff     = {base_ff[smac_pkg::ADDR_W-1:smac_pkg::GRAIN_SHIFT],
                          {smac_pkg::GRAIN_SHIFT{1'b0}}};
      cfg.window_bytes = wbytes_ff;
      cfg.redzone      = redzone_ff;
   end

   // classification of incoming items
   smac_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_address       (req_address),
      .req_length        (req_length),
      .req_object_length (req_object_length),
      .req_store         (req_store),
      .req_fill_code     (req_fill_code),
      .cfg               (cfg),
      .queue_full        (full),
      .clearing          (clearing),
      .push              (push),
      .job               (push_job)
   );

   // job queue
   smac_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (full)
   );

   // shadow store walker and result register
   smac_back u_back (
      .clock              (clock),
      .reset              (reset),
      .base_eff           (cfg.base_eff),
      .head               (head),
      .empty              (empty),
      .pop                (pop),
      .clearing           (clearing),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_report_address (rsp_report_address),
      .rsp_report_length  (rsp_report_length),
      .rsp_report_write   (rsp_report_write)
   );

endmodule

@@ hdl/smac_front.sv @@
// ----------------------------------------------------------------------------
// smac_front
// accepts items, does the window and alignment checks, builds jobs
// ----------------------------------------------------------------------------
module smac_front (
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [smac_pkg::OP_W-1:0]             req_operation,
   input  logic [smac_pkg::ADDR_W-1:0]           req_address,
   input  logic [smac_pkg::LEN_W-1:0]            req_length,
   input  logic [smac_pkg::LEN_W-1:0]            req_object_length,
   input  logic                                  req_store,
   input  logic [smac_pkg::CODE_W-1:0]           req_fill_code,
   input  smac_pkg::cfg_type                     cfg,
   input  logic                                  queue_full,
   input  logic                                  clearing,
   output logic                                  push,
   output smac_pkg::job_type                     job
);

   localparam int unsigned GS  = smac_pkg::GRAIN_SHIFT;
   localparam int unsigned OW  = smac_pkg::OFF_W;
   localparam int unsigned IW  = smac_pkg::IDX_W;

   logic [smac_pkg::ADDR_W-1:0]  off;
   logic [OW-1:0]                off_lo;
   logic [OW-1:0]                wb_ext;
   logic [OW-1:0]                end_acc;
   logic [OW-1:0]                e_last;
   logic [OW-1:0]                ru;
   logic [OW-1:0]                end_obj;
   logic                         off_in;
   logic                         end_acc_in;
   logic                         fill_fit;
   logic                         obj_fit;
   logic                         addr_misaligned;
   smac_pkg::op_type             op;

   assign req_stall = queue_full || clearing;
   assign push      = req_valid && !req_stall;

   always_comb begin
      op      = smac_pkg::op_type'(req_operation);
      off     = req_address - cfg.base_eff;
      off_lo  = off[OW-1:0];
      wb_ext  = OW'(cfg.window_bytes);
      off_in  = (off < 64'(cfg.window_bytes)) && (off < 64'(smac_pkg::WIN_LIMIT));
      end_acc = off_lo + OW'(req_length);
      e_last  = end_acc - OW'(1);
      end_acc_in = (end_acc < wb_ext) && (end_acc < OW'(smac_pkg::WIN_LIMIT));
      fill_fit   = (end_acc <= wb_ext) &&
                   (end_acc < OW'(smac_pkg::WIN_LIMIT + smac_pkg::GRAIN_BYTES));
      ru      = (OW'(req_object_length) + OW'(smac_pkg::GRAIN_MASK)) &
                ~OW'(smac_pkg::GRAIN_MASK);
      end_obj = off_lo + ru;
      obj_fit = (end_obj <= wb_ext) &&
                (end_obj < OW'(smac_pkg::WIN_LIMIT + smac_pkg::GRAIN_BYTES));
      addr_misaligned = (req_address[GS-1:0] != '0);

      job             = '0;
      job.kind        = smac_pkg::JOB_REPORT;
      job.status      = smac_pkg::ST_SKIPPED;
      job.address     = req_address;
      job.length      = req_length;
      job.write       = (op == smac_pkg::OP_CHECK_WORD || op == smac_pkg::OP_CHECK_REGION)
                        ? req_store : 1'b0;
      job.grain_first = off_lo[GS+IW-1:GS];
      job.lo          = off_lo[GS-1:0];
      job.hi          = e_last[GS-1:0];
      job.grain_count = smac_pkg::COUNT_W'(e_last[GS+IW-1:GS])
                        - smac_pkg::COUNT_W'(off_lo[GS+IW-1:GS])
                        + smac_pkg::COUNT_W'(1);
      job.word_last   = smac_pkg::LAST_W'(req_address[GS-1:0])
                        + smac_pkg::LAST_W'(req_length) - smac_pkg::LAST_W'(1);

      if (!cfg.enable) begin
         job.status = smac_pkg::ST_SKIPPED;
      end else begin
         case (op)
            smac_pkg::OP_CHECK_WORD,
            smac_pkg::OP_CHECK_REGION: begin
               if (req_address == '0 || req_length == '0) begin
                  job.status = smac_pkg::ST_SKIPPED;
               end else if (!req_address[smac_pkg::ADDR_W-1]) begin
                  job.status = smac_pkg::ST_USER;
               end else if (!off_in || !end_acc_in) begin
                  job.status = smac_pkg::ST_SKIPPED;
               end else if (op == smac_pkg::OP_CHECK_WORD) begin
                  job.kind = smac_pkg::JOB_WORD;
               end else begin
                  job.kind = smac_pkg::JOB_REGION;
               end
            end
            smac_pkg::OP_FILL: begin
               if (addr_misaligned || req_length[GS-1:0] != '0 || !off_in || !fill_fit) begin
                  job.status = smac_pkg::ST_REJECTED;
               end else begin
                  job.kind        = smac_pkg::JOB_FILL;
                  job.code        = req_fill_code;
                  job.grain_count = smac_pkg::COUNT_W'(req_length >> GS);
               end
            end
            smac_pkg::OP_MARK_ALLOC: begin
               if (req_address == '0) begin
                  job.status = smac_pkg::ST_SKIPPED;
               end else if (addr_misaligned || !off_in || !obj_fit ||
                            req_length > req_object_length) begin
                  job.status = smac_pkg::ST_REJECTED;
               end else begin
                  job.kind        = smac_pkg::JOB_FILL;
                  job.code        = cfg.redzone;
                  job.grain_count = smac_pkg::COUNT_W'(ru >> GS);
                  job.zero_count  = smac_pkg::COUNT_W'(req_length >> GS);
                  job.tail        = req_length[GS-1:0];
               end
            end
            default: begin
               job.status = smac_pkg::ST_SKIPPED;
            end
         endcase
      end
   end

endmodule

@@ hdl/smac_queue.sv @@
// ----------------------------------------------------------------------------
// smac_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module smac_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  smac_pkg::job_type   push_job,
   input  logic                pop,
   output smac_pkg::job_type   head,
   output logic                empty,
   output logic                full
);

   smac_pkg::job_type   slot_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                do_push, do_pop;

   assign empty   = (count_ff == 2'd0);
   assign full    = (count_ff == 2'd2);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ hdl/smac_back.sv @@
// ----------------------------------------------------------------------------
// smac_back
// shadow store, grain walker and result register
// ----------------------------------------------------------------------------
module smac_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [smac_pkg::ADDR_W-1:0]         base_eff,
   input  smac_pkg::job_type                   head,
   input  logic                                empty,
   output logic                                pop,
   output logic                                clearing,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [smac_pkg::STATUS_W-1:0]       rsp_status,
   output logic [smac_pkg::ADDR_W-1:0]         rsp_report_address,
   output logic [smac_pkg::LEN_W-1:0]          rsp_report_length,
   output logic                                rsp_report_write
);

   localparam int unsigned GS = smac_pkg::GRAIN_SHIFT;
   localparam int unsigned IW = smac_pkg::IDX_W;
   localparam int unsigned CW = smac_pkg::COUNT_W;

   logic [smac_pkg::CODE_W-1:0]   shadow_mem [smac_pkg::SHADOW_ENTRIES];

   smac_pkg::back_state_type      state_ff, state_in;
   smac_pkg::job_type             job_ff, job_in;
   logic [IW-1:0]                 g_ff, g_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [CW-1:0]                 pos_ff, pos_in;
   smac_pkg::status_type          res_status_ff, res_status_in;
   logic [smac_pkg::ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic [smac_pkg::CODE_W-1:0]   rd_data_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [smac_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [smac_pkg::ADDR_W-1:0]   rsp_addr_ff;
   logic [smac_pkg::LEN_W-1:0]    rsp_len_ff;
   logic                          rsp_write_ff;

   logic                          out_free;
   logic                          emit;
   logic                          mem_we;
   logic [smac_pkg::CODE_W-1:0]   mem_wdata;
   logic [smac_pkg::CODE_W-1:0]   s;
   logic                          s_neg, s_pos;
   logic [GS-1:0]                 lo, hi, hit_pos;
   logic                          hit;
   logic                          first_grain, last_grain;

   assign out_free           = !rsp_valid_ff || !rsp_stall;
   assign clearing           = (state_ff == smac_pkg::B_CLEAR);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_report_address = rsp_addr_ff;
   assign rsp_report_length  = rsp_len_ff;
   assign rsp_report_write   = rsp_write_ff;

   // per-grain poison test of the region walk
   always_comb begin
      s           = rd_data_ff;
      s_neg       = s[smac_pkg::CODE_W-1];
      s_pos       = !s_neg && (s != '0);
      first_grain = (g_ff == job_ff.grain_first);
      last_grain  = (cnt_ff == CW'(1));
      lo          = first_grain ? job_ff.lo : '0;
      hi          = last_grain ? job_ff.hi : GS'(smac_pkg::GRAIN_MASK);
      hit         = s_neg || (s_pos && (s <= smac_pkg::CODE_W'(hi)));
      hit_pos     = (s_pos && (s > smac_pkg::CODE_W'(lo))) ? s[GS-1:0] : lo;
   end

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      g_in          = g_ff;
      cnt_in        = cnt_ff;
      pos_in        = pos_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      pop           = 1'b0;
      emit          = 1'b0;
      mem_we        = 1'b0;
      mem_wdata     = '0;

      case (state_ff)
         smac_pkg::B_CLEAR: begin
            mem_we = 1'b1;
            g_in   = g_ff + IW'(1);
            if (g_ff == IW'(smac_pkg::SHADOW_ENTRIES - 1)) begin
               state_in = smac_pkg::B_IDLE;
            end
         end
         smac_pkg::B_IDLE: begin
            if (!empty) begin
               pop           = 1'b1;
               job_in        = head;
               g_in          = head.grain_first;
               cnt_in        = head.grain_count;
               pos_in        = '0;
               res_status_in = head.status;
               res_addr_in   = head.address;
               case (head.kind)
                  smac_pkg::JOB_REPORT: state_in = smac_pkg::B_EMIT;
                  smac_pkg::JOB_WORD:   state_in = smac_pkg::B_WORD_READ;
                  smac_pkg::JOB_REGION: state_in = smac_pkg::B_REGION_READ;
                  smac_pkg::JOB_FILL: begin
                     res_status_in = smac_pkg::ST_MARKED;
                     state_in = (head.grain_count == '0) ? smac_pkg::B_EMIT
                                                         : smac_pkg::B_FILL;
                  end
                  default: state_in = smac_pkg::B_EMIT;
               endcase
            end
         end
         smac_pkg::B_WORD_READ: begin
            state_in = smac_pkg::B_WORD_CHECK;
         end
         smac_pkg::B_WORD_CHECK: begin
            if (s != '0 && (s_neg || job_ff.word_last >= smac_pkg::LAST_W'(s))) begin
               res_status_in = smac_pkg::ST_POISONED;
            end else begin
               res_status_in = smac_pkg::ST_CLEAN;
            end
            state_in = smac_pkg::B_EMIT;
         end
         smac_pkg::B_REGION_READ: begin
            state_in = smac_pkg::B_REGION_CHECK;
         end
         smac_pkg::B_REGION_CHECK: begin
            if (hit) begin
               res_status_in = smac_pkg::ST_POISONED;
               res_addr_in   = base_eff + smac_pkg::ADDR_W'({g_ff, hit_pos});
               state_in      = smac_pkg::B_EMIT;
            end else if (last_grain) begin
               res_status_in = smac_pkg::ST_CLEAN;
               state_in      = smac_pkg::B_EMIT;
            end else begin
               g_in     = g_ff + IW'(1);
               cnt_in   = cnt_ff - CW'(1);
               state_in = smac_pkg::B_REGION_READ;
            end
         end
         smac_pkg::B_FILL: begin
            mem_we = 1'b1;
            if (pos_ff < job_ff.zero_count) begin
               mem_wdata = '0;
            end else if (pos_ff == job_ff.zero_count && job_ff.tail != '0) begin
               mem_wdata = smac_pkg::CODE_W'(job_ff.tail);
            end else begin
               mem_wdata = job_ff.code;
            end
            g_in   = g_ff + IW'(1);
            pos_in = pos_ff + CW'(1);
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = smac_pkg::B_EMIT;
            end
         end
         smac_pkg::B_EMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = smac_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = smac_pkg::B_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smac_pkg::B_CLEAR;
         g_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         g_ff         <= g_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      cnt_ff        <= cnt_in;
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      if (emit) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_len_ff    <= job_ff.length;
         rsp_write_ff  <= job_ff.write;
      end
   end

   // shadow store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         shadow_mem[g_ff] <= mem_wdata;
      end
      rd_data_ff <= shadow_mem[g_ff];
   end

`ifndef SYNTHESIS
   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smac_pkg::B_CLEAR) |-> !pop)
      else $error("job taken during shadow clear");
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == smac_pkg::B_EMIT))
      else $error("result raised outside emit");
   a_emit_to_idle: assert property (@(posedge clock) disable iff (reset)
      emit |=> (state_ff == smac_pkg::B_IDLE))
      else $error("back did not return to idle after emit");
   a_fill_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smac_pkg::B_FILL) |-> (cnt_ff != '0))
      else $error("fill step with no grains left");
`endif

endmodule
